// ===== sv/vpts_pkg.sv =====
// Shared constants and types for the vertex projection block.
package vpts_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 32;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_VP_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VP_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VP_W = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VP_H = 2'd3;

  localparam int ACT_W = 2;
  localparam logic [ACT_W-1:0] ACT_PROJECT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MODEL_WR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PROJ_WR  = 2'd2;

  localparam int IDX_W       = 4;
  localparam int MAT_N       = 16;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    KIND_PROJECT = 1'b0,
    KIND_PWRITE  = 1'b1
  } kind_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_diag(input int i);
    return (i % 5) == 0;
  endfunction

endpackage

// ===== sv/vpts_sat.sv =====
// Signed saturation from a wide value to a narrower one.
module vpts_sat #(
  parameter int IW = 40,
  parameter int OW = 32
) (
  input  logic signed [IW-1:0] in_v,
  output logic signed [OW-1:0] out_v
);
  localparam logic signed [OW-1:0] MAX_V = {1'b0, {(OW-1){1'b1}}};
  localparam logic signed [OW-1:0] MIN_V = {1'b1, {(OW-1){1'b0}}};
  logic fits;

  assign fits  = (&in_v[IW-1:OW-1]) || ~(|in_v[IW-1:OW-1]);
  assign out_v = fits ? in_v[OW-1:0] : (in_v[IW-1] ? MIN_V : MAX_V);
endmodule

// ===== sv/vpts_queue.sv =====
// Small register queue with full and empty status.
module vpts_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = vpts_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output vpts_pkg::q_stat_t stat
);
  import vpts_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end
endmodule

// ===== sv/vpts_div.sv =====
// Pipelined restoring divider lane computing saturated (n << F) / d toward zero.
module vpts_div #(
  parameter int FRAC_BITS   = vpts_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = vpts_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] num,
  input  logic signed [COORD_WIDTH-1:0] den,
  output logic signed [COORD_WIDTH-1:0] quo
);
  import vpts_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int F = FRAC_BITS;
  localparam int N = W + F;
  localparam logic signed [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0] rem_r [N+1];
  logic [N-1:0] q_r   [N+1];
  logic [N-1:0] nm_r  [N+1];
  logic [W-1:0] ud_r  [N+1];
  logic         ng_r  [N+1];
  logic [W-1:0] un, ud;
  logic [N-1:0] qf;
  logic         over_neg, over_pos;
  logic signed [W-1:0] quo_r;

  assign un = num[W-1] ? W'(-num) : W'(num);
  assign ud = den[W-1] ? W'(-den) : W'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      q_r[0]   <= '0;
      nm_r[0]  <= {un, {F{1'b0}}};
      ud_r[0]  <= ud;
      ng_r[0]  <= num[W-1] ^ den[W-1];
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [W:0] trial, diff;
    logic       ge;
    assign trial = {rem_r[k-1], nm_r[k-1][N-1]};
    assign diff  = trial - {1'b0, ud_r[k-1]};
    assign ge    = (trial >= {1'b0, ud_r[k-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[W-1:0] : trial[W-1:0];
        q_r[k]   <= {q_r[k-1][N-2:0], ge};
        nm_r[k]  <= nm_r[k-1] << 1;
        ud_r[k]  <= ud_r[k-1];
        ng_r[k]  <= ng_r[k-1];
      end
    end
  end

  assign qf       = q_r[N];
  assign over_pos = |qf[N-1:W-1];
  assign over_neg = (|qf[N-1:W]) || (qf[W-1] && (|qf[W-2:0]));

  always_ff @(posedge clk) begin
    if (en) begin
      if (ng_r[N]) begin
        quo_r <= over_neg ? MIN_V : -$signed(qf[W-1:0]);
      end else begin
        quo_r <= over_pos ? MAX_V : $signed(qf[W-1:0]);
      end
    end
  end

  assign quo = quo_r;
endmodule

// ===== sv/vpts_front.sv =====
// Front part: takes input beats, holds the model matrix and forms eye vectors.
module vpts_front #(
  parameter int FRAC_BITS   = vpts_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = vpts_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              advance,
  input  logic                              in_acc,
  input  logic [vpts_pkg::ACT_W-1:0]        action,
  input  logic [vpts_pkg::IDX_W-1:0]        coef_index,
  input  logic signed [COORD_WIDTH-1:0]     coef_value,
  input  logic signed [COORD_WIDTH-1:0]     point_x,
  input  logic signed [COORD_WIDTH-1:0]     point_y,
  input  logic signed [COORD_WIDTH-1:0]     point_z,
  output logic                              item_v,
  output logic [1+vpts_pkg::IDX_W+4*COORD_WIDTH-1:0] item
);
  import vpts_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int SW = PW + 2;
  localparam int TW = SW - F;
  localparam int EPS_RAW = ((1 << F) + 500) / 1000;
  localparam int EPS     = (EPS_RAW < 1) ? 1 : EPS_RAW;
  localparam logic signed [W-1:0] NEG_EPS = -(W'(EPS));
  localparam logic signed [W-1:0] ONE_V   = W'(1) << F;

  logic signed [W-1:0]  mm_r [MAT_N];
  logic signed [W-1:0]  pt [3];
  logic signed [PW-1:0] prod_r [4][3];
  logic signed [W-1:0]  tr_r [4];
  logic                 v1_r, v2_r, travels;
  kind_t                kind1_r, kind2_r;
  logic [IDX_W-1:0]     idx1_r, idx2_r;
  logic signed [W-1:0]  val1_r;
  logic signed [W-1:0]  eye [4];
  logic signed [W-1:0]  e_r [4];

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  always_comb begin
    travels = in_acc && (action inside {ACT_PROJECT, ACT_PROJ_WR});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_N; i++) begin
        mm_r[i] <= is_diag(i) ? ONE_V : '0;
      end
    end else if (in_acc && action == ACT_MODEL_WR) begin
      mm_r[coef_index] <= coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (advance) begin
      v1_r <= travels;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= PW'(mm_r[c*4+r]) * PW'(pt[c]);
        end
        tr_r[r] <= mm_r[12+r];
      end
      kind1_r <= (action == ACT_PROJ_WR) ? KIND_PWRITE : KIND_PROJECT;
      idx1_r  <= coef_index;
      val1_r  <= coef_value;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    logic signed [SW-1:0] sum;
    logic signed [TW-1:0] sh;
    assign sum = SW'(prod_r[r][0]) + SW'(prod_r[r][1]) + SW'(prod_r[r][2])
               + (SW'(tr_r[r]) <<< F);
    assign sh  = TW'(sum >>> F);
    vpts_sat #(.IW(TW), .OW(W)) u_sat (.in_v(sh), .out_v(eye[r]));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind2_r <= kind1_r;
      idx2_r  <= idx1_r;
      e_r[0]  <= (kind1_r == KIND_PWRITE) ? val1_r : eye[0];
      e_r[1]  <= eye[1];
      e_r[2]  <= (eye[2] > 0) ? NEG_EPS : eye[2];
      e_r[3]  <= eye[3];
    end
  end

  assign item_v = v2_r;
  assign item   = {kind2_r, idx2_r, e_r[3], e_r[2], e_r[1], e_r[0]};
endmodule

// ===== sv/vpts_back.sv =====
// Back part: projection matrix, perspective divide and viewport mapping.
module vpts_back #(
  parameter int FRAC_BITS   = vpts_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = vpts_pkg::COORD_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       advance,
  input  logic                                       q_valid,
  input  logic [1+vpts_pkg::IDX_W+4*COORD_WIDTH-1:0] q_item,
  input  logic [vpts_pkg::CFG_W-1:0]                 vp_x,
  input  logic [vpts_pkg::CFG_W-1:0]                 vp_y,
  input  logic [vpts_pkg::CFG_W-1:0]                 vp_w,
  input  logic [vpts_pkg::CFG_W-1:0]                 vp_h,
  output logic                                       pop,
  output logic                                       res_push,
  output logic [3*COORD_WIDTH:0]                     res_data
);
  import vpts_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int IW = 1 + IDX_W + 4 * W;
  localparam int PW = 2 * W;
  localparam int SW = PW + 2;
  localparam int TW = SW - F;
  localparam int LD = W + F + 2;
  localparam int MW = W + CFG_W + 1;
  localparam int AW = MW + 1;
  localparam logic signed [W-1:0] ONE_V    = W'(1) << F;
  localparam logic signed [W:0]   HALF_ONE = {{(W-F){1'b0}}, 1'b1, {F{1'b0}}};

  logic signed [W-1:0]  pm_r [MAT_N];
  kind_t                kind;
  logic [IDX_W-1:0]     idx;
  logic signed [W-1:0]  eye [4];
  logic signed [PW-1:0] pp_r [4][4];
  logic                 v1_r, v2_r;
  logic signed [W-1:0]  clip [4];
  logic signed [W-1:0]  clip_r [4];
  logic signed [W-1:0]  quo [3];
  logic                 dv_r [LD];
  logic                 dnz_r [LD];
  logic signed [W-1:0]  t_r [3];
  logic                 hv_r, hnz_r, mv_r, mnz_r;
  logic signed [MW-1:0] mx_r, my_r;
  logic signed [W-1:0]  mz_r;
  logic signed [AW-1:0] ax, ay;
  logic signed [W-1:0]  sx, sy;

  assign kind = kind_t'(q_item[IW-1]);
  assign idx  = q_item[IW-2 -: IDX_W];
  for (genvar i = 0; i < 4; i++) begin : g_unpack
    assign eye[i] = q_item[i*W +: W];
  end

  assign pop = advance && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_N; i++) begin
        pm_r[i] <= is_diag(i) ? ONE_V : '0;
      end
    end else if (pop && kind == KIND_PWRITE) begin
      pm_r[idx] <= eye[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      hv_r <= 1'b0;
      mv_r <= 1'b0;
      for (int i = 0; i < LD; i++) begin
        dv_r[i] <= 1'b0;
      end
    end else if (advance) begin
      v1_r    <= pop && kind == KIND_PROJECT;
      v2_r    <= v1_r;
      dv_r[0] <= v2_r;
      for (int i = 1; i < LD; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
      hv_r <= dv_r[LD-1];
      mv_r <= hv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          pp_r[r][c] <= PW'(pm_r[c*4+r]) * PW'(eye[c]);
        end
      end
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    logic signed [SW-1:0] sum;
    logic signed [TW-1:0] sh;
    assign sum = SW'(pp_r[r][0]) + SW'(pp_r[r][1]) + SW'(pp_r[r][2]) + SW'(pp_r[r][3]);
    assign sh  = TW'(sum >>> F);
    vpts_sat #(.IW(TW), .OW(W)) u_sat (.in_v(sh), .out_v(clip[r]));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < 4; r++) begin
        clip_r[r] <= clip[r];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    vpts_div #(.FRAC_BITS(F), .COORD_WIDTH(W)) u_div (
      .clk (clk),
      .en  (advance),
      .num (clip_r[k]),
      .den (clip_r[3]),
      .quo (quo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dnz_r[0] <= (clip_r[3] != '0);
      for (int i = 1; i < LD; i++) begin
        dnz_r[i] <= dnz_r[i-1];
      end
      hnz_r <= dnz_r[LD-1];
      for (int k = 0; k < 3; k++) begin
        t_r[k] <= W'(((W+1)'(quo[k]) + HALF_ONE) >>> 1);
      end
      mnz_r <= hnz_r;
      mx_r  <= MW'(t_r[0]) * MW'($signed({1'b0, vp_w}));
      my_r  <= MW'(t_r[1]) * MW'($signed({1'b0, vp_h}));
      mz_r  <= t_r[2];
    end
  end

  assign ax = AW'(mx_r) + (AW'($signed({1'b0, vp_x})) <<< F);
  assign ay = AW'(my_r) + (AW'($signed({1'b0, vp_y})) <<< F);
  vpts_sat #(.IW(AW), .OW(W)) u_sat_x (.in_v(ax), .out_v(sx));
  vpts_sat #(.IW(AW), .OW(W)) u_sat_y (.in_v(ay), .out_v(sy));

  assign res_push = mv_r && advance;
  assign res_data = mnz_r ? {1'b1, mz_r, sy, sx} : '0;
endmodule

// ===== sv/vertex_project_to_screen_core.sv =====
// Top level of the vertex projection block: configuration, front, queues and back.
//
//   channel  ports                       direction  beat taken when
//   in       in_push / in_full + fields  input      in_push && !in_full
//   out      out_pop / out_empty + fields output    out_pop && !out_empty
//   cfg      cfg_we, cfg_index, cfg_wdata input      cfg_we
//
// One beat is accepted per cycle while the mid queue is not full; a projection passes the
// front, the mid queue and the back, whose divider resolves one bit per stage.
// Matrix writes take effect for every later point; model writes at once, projection
// writes when they pass the mid queue. Reset is synchronous and loads identity matrices.
// A full result queue freezes the back part; the front runs until the mid queue fills.
module vertex_project_to_screen_core #(
  parameter int FRAC_BITS   = vpts_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = vpts_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [vpts_pkg::ACT_W-1:0]        in_action,
  input  logic [vpts_pkg::IDX_W-1:0]        in_coef_index,
  input  logic signed [COORD_WIDTH-1:0]     in_coef_value,
  input  logic signed [COORD_WIDTH-1:0]     in_point_x,
  input  logic signed [COORD_WIDTH-1:0]     in_point_y,
  input  logic signed [COORD_WIDTH-1:0]     in_point_z,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [COORD_WIDTH-1:0]     out_screen_x,
  output logic signed [COORD_WIDTH-1:0]     out_screen_y,
  output logic signed [COORD_WIDTH-1:0]     out_screen_depth,
  output logic                              out_valid_res,
  input  logic                              cfg_we,
  input  logic [vpts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vpts_pkg::CFG_W-1:0]        cfg_wdata
);
  import vpts_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int IW = 1 + IDX_W + 4 * W;
  localparam int RW = 3 * W + 1;

  logic [CFG_W-1:0] vp_x_r, vp_y_r, vp_w_r, vp_h_r;
  logic             in_acc, adv_f, adv_b;
  logic             f_item_v, b_pop, b_push;
  logic [IW-1:0]    f_item, q_item;
  logic [RW-1:0]    res_data, res_head;
  q_stat_t          mid_stat, out_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_x_r <= '0;
      vp_y_r <= '0;
      vp_w_r <= '0;
      vp_h_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VP_X: vp_x_r <= cfg_wdata;
        CFG_VP_Y: vp_y_r <= cfg_wdata;
        CFG_VP_W: vp_w_r <= cfg_wdata;
        CFG_VP_H: vp_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_full = mid_stat.full;
  assign adv_f   = !mid_stat.full;
  assign in_acc  = in_push && !in_full;
  assign adv_b   = !out_stat.full;

  vpts_front #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(W)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (adv_f),
    .in_acc     (in_acc),
    .action     (in_action),
    .coef_index (in_coef_index),
    .coef_value (in_coef_value),
    .point_x    (in_point_x),
    .point_y    (in_point_y),
    .point_z    (in_point_z),
    .item_v     (f_item_v),
    .item       (f_item)
  );

  vpts_queue #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_item_v && adv_f),
    .wdata (f_item),
    .pop   (b_pop),
    .rdata (q_item),
    .stat  (mid_stat)
  );

  vpts_back #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(W)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (adv_b),
    .q_valid  (!mid_stat.empty),
    .q_item   (q_item),
    .vp_x     (vp_x_r),
    .vp_y     (vp_y_r),
    .vp_w     (vp_w_r),
    .vp_h     (vp_h_r),
    .pop      (b_pop),
    .res_push (b_push),
    .res_data (res_data)
  );

  vpts_queue #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (b_push),
    .wdata (res_data),
    .pop   (out_pop),
    .rdata (res_head),
    .stat  (out_stat)
  );

  assign out_empty        = out_stat.empty;
  assign out_screen_x     = res_head[W-1:0];
  assign out_screen_y     = res_head[2*W-1:W];
  assign out_screen_depth = res_head[3*W-1:2*W];
  assign out_valid_res    = res_head[3*W];
endmodule

// ===== sv/vpts_check.sv =====
// Port-level checks for the vertex projection block, bound to the top level.
module vpts_check #(
  parameter int COORD_WIDTH = vpts_pkg::COORD_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_full,
  input logic                          out_empty,
  input logic                          out_pop,
  input logic signed [COORD_WIDTH-1:0] out_screen_x,
  input logic signed [COORD_WIDTH-1:0] out_screen_y,
  input logic signed [COORD_WIDTH-1:0] out_screen_depth,
  input logic                          out_valid_res
);
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not cleared by reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_valid_res) |->
      (out_screen_x == '0 && out_screen_y == '0 && out_screen_depth == '0))
    else $error("result with zero w carries nonzero fields");

  a_full_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("input stalled while no result waits");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_screen_x) &&
      $stable(out_screen_y) && $stable(out_screen_depth) && $stable(out_valid_res)))
    else $error("waiting result beat changed");
endmodule

bind vertex_project_to_screen_core vpts_check #(.COORD_WIDTH(COORD_WIDTH)) u_vpts_check (.*);
